// ----- hw/rtl/swmq_pkg.sv -----
// Shared constants, types and index helpers for the sliding window max queue.
// Used by the controller, the top level and the port checker.
package swmq_pkg;

	localparam int DEPTH       = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int AW          = $clog2(DEPTH);
	localparam int CW          = $clog2(DEPTH + 1);

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	typedef struct packed {
		logic                   we;
		logic [AW-1:0]          waddr;
		logic [VALUE_WIDTH-1:0] wdata;
		logic                   re;
		logic [AW-1:0]          raddr;
	} mem_req_t;

	// Circular index: base + off, wrapped once at DEPTH (base < DEPTH, off <= DEPTH).
	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

endpackage

// ----- hw/rtl/swmq_ram.sv -----
// Generic single-clock RAM: one write port, one registered read port.
// No package dependency.
module swmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/swmq_ctrl.sv -----
// Sequencer for the max queue: heads, counts, cached maximum and result registers.
// Drives read/write requests to the FIFO and deque RAMs; depends on swmq_pkg.
module swmq_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [1:0]                      cmd,
	input  logic [swmq_pkg::VALUE_WIDTH-1:0] value,
	output logic                            busy,
	output logic                            done,
	output logic [swmq_pkg::VALUE_WIDTH-1:0] max_value,
	output logic                            is_empty,
	output logic [swmq_pkg::CW-1:0]         count,
	output logic [1:0]                      error,
	output swmq_pkg::mem_req_t              fifo_req,
	output swmq_pkg::mem_req_t              deq_req,
	input  logic [swmq_pkg::VALUE_WIDTH-1:0] fifo_rdata,
	input  logic [swmq_pkg::VALUE_WIDTH-1:0] deq_rdata
);
	import swmq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;

	logic [1:0]             state_q, state_n;
	logic [AW-1:0]          fhead_q, fhead_n, dhead_q, dhead_n;
	logic [CW-1:0]          fcount_q, fcount_n, dcount_q, dcount_n;
	logic [VALUE_WIDTH-1:0] max_q, max_n, val_q, val_n;
	logic                   finish;
	logic [1:0]             err_n;

	function automatic logic [CW-1:0] back_off(logic [CW-1:0] n);
		return (n == '0) ? '0 : n - CW'(1);
	endfunction

	always_comb begin
		state_n  = state_q;
		fhead_n  = fhead_q;
		dhead_n  = dhead_q;
		fcount_n = fcount_q;
		dcount_n = dcount_q;
		max_n    = max_q;
		val_n    = val_q;
		finish   = 1'b0;
		err_n    = ERR_OK;
		fifo_req = '0;
		deq_req  = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_PUSH: begin
							if (fcount_q == CW'(DEPTH)) begin
								err_n  = ERR_FULL;
								finish = 1'b1;
							end else begin
								fifo_req.we    = 1'b1;
								fifo_req.waddr = wrap_add(fhead_q, fcount_q);
								fifo_req.wdata = value;
								fcount_n       = fcount_q + CW'(1);
								// fetch the deque back for the first compare
								deq_req.re     = 1'b1;
								deq_req.raddr  = wrap_add(dhead_q, back_off(dcount_q));
								val_n          = value;
								state_n        = ST_SCAN;
							end
						end
						CMD_POP: begin
							if (fcount_q == '0) begin
								err_n  = ERR_EMPTY;
								finish = 1'b1;
							end else begin
								fifo_req.re    = 1'b1;
								fifo_req.raddr = fhead_q;
								// prefetch the next deque head in case this one leaves
								deq_req.re     = 1'b1;
								deq_req.raddr  = wrap_add(dhead_q, CW'(1));
								state_n        = ST_POP;
							end
						end
						CMD_CLEAR: begin
							fhead_n  = '0;
							dhead_n  = '0;
							fcount_n = '0;
							dcount_n = '0;
							finish   = 1'b1;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (dcount_q != '0 && deq_rdata < val_q) begin
					// drop the smaller back entry, fetch the one before it
					dcount_n      = dcount_q - CW'(1);
					deq_req.re    = 1'b1;
					deq_req.raddr = wrap_add(dhead_q, back_off(dcount_n));
				end else begin
					deq_req.we    = 1'b1;
					deq_req.waddr = wrap_add(dhead_q, dcount_q);
					deq_req.wdata = val_q;
					dcount_n      = dcount_q + CW'(1);
					if (dcount_q == '0) begin
						max_n = val_q;
					end
					finish  = 1'b1;
					state_n = ST_IDLE;
				end
			end
			ST_POP: begin
				if (dcount_q != '0 && fifo_rdata == max_q) begin
					dhead_n  = wrap_add(dhead_q, CW'(1));
					dcount_n = dcount_q - CW'(1);
					max_n    = deq_rdata;
				end
				fhead_n  = wrap_add(fhead_q, CW'(1));
				fcount_n = fcount_q - CW'(1);
				finish   = 1'b1;
				state_n  = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fhead_q  <= '0;
			dhead_q  <= '0;
			fcount_q <= '0;
			dcount_q <= '0;
			done     <= 1'b0;
			is_empty <= 1'b1;
			count    <= '0;
			error    <= ERR_OK;
		end else begin
			state_q  <= state_n;
			fhead_q  <= fhead_n;
			dhead_q  <= dhead_n;
			fcount_q <= fcount_n;
			dcount_q <= dcount_n;
			done     <= finish;
			if (finish) begin
				is_empty <= (fcount_n == '0);
				count    <= fcount_n;
				error    <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		max_q <= max_n;
		val_q <= val_n;
		if (finish) begin
			max_value <= (fcount_n != '0 && dcount_n != '0) ? max_n : '0;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- hw/rtl/sliding_window_max_queue.sv -----
// Sliding window max queue: FIFO of values that reports its running maximum.
// Clear, read and rejected commands finish from idle; pop passes through the pop state;
// push passes through the scan state, dropping deque back entries one per deque RAM read.
// Throughput: a new command may start in the cycle its result is shown.
// Reset clears heads and counts at once; RAM contents are not cleared.
// Each result is shown for one cycle on done; the receiver cannot stall.
module sliding_window_max_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      cmd,
	input  logic [swmq_pkg::VALUE_WIDTH-1:0] value,
	output logic                            done,
	output logic [swmq_pkg::VALUE_WIDTH-1:0] max_value,
	output logic                            is_empty,
	output logic [swmq_pkg::CW-1:0]         count,
	output logic [1:0]                      error
);
	import swmq_pkg::*;

	mem_req_t               fifo_req, deq_req;
	logic [VALUE_WIDTH-1:0] fifo_rdata, deq_rdata;

	swmq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.value      (value),
		.busy       (busy),
		.done       (done),
		.max_value  (max_value),
		.is_empty   (is_empty),
		.count      (count),
		.error      (error),
		.fifo_req   (fifo_req),
		.deq_req    (deq_req),
		.fifo_rdata (fifo_rdata),
		.deq_rdata  (deq_rdata)
	);

	swmq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_req.we),
		.waddr (fifo_req.waddr),
		.wdata (fifo_req.wdata),
		.re    (fifo_req.re),
		.raddr (fifo_req.raddr),
		.rdata (fifo_rdata)
	);

	swmq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_deq_ram (
		.clk   (clk),
		.we    (deq_req.we),
		.waddr (deq_req.waddr),
		.wdata (deq_req.wdata),
		.re    (deq_req.re),
		.raddr (deq_req.raddr),
		.rdata (deq_rdata)
	);

endmodule

// ----- hw/rtl/swmq_check.sv -----
// Port-level checker for sliding_window_max_queue, bound to the top level.
// Depends on swmq_pkg for depth and error codes.
module swmq_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [swmq_pkg::VALUE_WIDTH-1:0] max_value,
	input logic                            is_empty,
	input logic [swmq_pkg::CW-1:0]         count,
	input logic [1:0]                      error
);
	import swmq_pkg::*;

	// an accepted beat either shows its result next cycle or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither busy nor done");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_empty) |-> (max_value == '0 && count == '0))
		else $error("empty result with nonzero max or count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count <= CW'(DEPTH) && is_empty == (count == '0)))
		else $error("count out of range or disagrees with is_empty");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error == ERR_EMPTY) |-> is_empty)
		else $error("pop-empty error on a nonempty queue");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error == ERR_FULL) |-> (count == CW'(DEPTH)))
		else $error("push-full error while not full");

endmodule

bind sliding_window_max_queue swmq_check u_check (.*);

// ----- tb/tb_sliding_window_max_queue.sv -----
// Self-checking testbench for the sliding window max queue: drives push, pop, clear
// and read commands and checks every result against an in-order max-queue predictor.
// Depends on swmq_pkg and the sliding_window_max_queue top level.
module tb_sliding_window_max_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import swmq_pkg::*;

	localparam int ITEMS      = 950;
	localparam int CYCLE_CAP  = 1_200_000;
	localparam int PRINT_CAP  = 40;

	typedef struct {
		logic [VALUE_WIDTH-1:0] mx;
		logic                   empty;
		logic [CW-1:0]          cnt;
		logic [1:0]             err;
	} queue_status_t;

	class maxq_checker;
		logic [VALUE_WIDTH-1:0] fifo_mem [DEPTH];
		logic [VALUE_WIDTH-1:0] cand_mem [DEPTH];
		int unsigned            fifo_rd;
		int unsigned            fifo_cnt;
		int unsigned            cand_rd;
		int unsigned            cand_cnt;
		queue_status_t          status_due [$];
		int                     mismatches;

		task report(string msg);
			if (mismatches < PRINT_CAP) begin
				$display("%0t mismatch: %s", $realtime, msg);
			end
			mismatches++;
		endtask

		// Apply one accepted command to the predicted queue and log the status it yields.
		function void note_command(logic [1:0] c, logic [VALUE_WIDTH-1:0] v);
			queue_status_t s;
			s.err = ERR_OK;
			case (c)
				CMD_PUSH: begin
					if (fifo_cnt >= DEPTH) begin
						s.err = ERR_FULL;
					end else begin
						fifo_mem[(fifo_rd + fifo_cnt) % DEPTH] = v;
						fifo_cnt++;
						// drop smaller candidates at the back; equal ones stay
						while (cand_cnt > 0 && cand_mem[(cand_rd + cand_cnt - 1) % DEPTH] < v)
							cand_cnt--;
						cand_mem[(cand_rd + cand_cnt) % DEPTH] = v;
						cand_cnt++;
					end
				end
				CMD_POP: begin
					if (fifo_cnt == 0) begin
						s.err = ERR_EMPTY;
					end else begin
						if (cand_cnt > 0 && fifo_mem[fifo_rd] == cand_mem[cand_rd]) begin
							cand_rd = (cand_rd + 1) % DEPTH;
							cand_cnt--;
						end
						fifo_rd = (fifo_rd + 1) % DEPTH;
						fifo_cnt--;
					end
				end
				CMD_CLEAR: begin
					fifo_rd  = 0;
					fifo_cnt = 0;
					cand_rd  = 0;
					cand_cnt = 0;
				end
				default: begin
				end
			endcase
			s.mx    = (fifo_cnt > 0 && cand_cnt > 0) ? cand_mem[cand_rd] : '0;
			s.empty = (fifo_cnt == 0);
			s.cnt   = CW'(fifo_cnt);
			status_due = {status_due, s};
		endfunction

		task check_status(logic [VALUE_WIDTH-1:0] mx, logic emp, logic [CW-1:0] cnt,
				logic [1:0] err);
			queue_status_t want;
			if (status_due.size() == 0) begin
				report("result beat with no command outstanding");
				return;
			end
			want = status_due[0];
			status_due.delete(0);
			if (mx !== want.mx)
				report($sformatf("max_value got %h want %h", mx, want.mx));
			if (emp !== want.empty)
				report($sformatf("is_empty got %b want %b", emp, want.empty));
			if (cnt !== want.cnt)
				report($sformatf("count got %0d want %0d", cnt, want.cnt));
			if (err !== want.err)
				report($sformatf("error got %0d want %0d", err, want.err));
		endtask
	endclass

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start  = 1'b0;
	logic [1:0]             cmd    = CMD_READ;
	logic [VALUE_WIDTH-1:0] value  = '0;
	logic                   busy;
	logic                   done;
	logic [VALUE_WIDTH-1:0] max_value;
	logic                   is_empty;
	logic [CW-1:0]          count;
	logic [1:0]             error;

	maxq_checker            sb = new();
	int                     sent;
	int unsigned            cycles;
	bit                     no_idle;
	logic [VALUE_WIDTH-1:0] trend;

	sliding_window_max_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.value     (value),
		.done      (done),
		.max_value (max_value),
		.is_empty  (is_empty),
		.count     (count),
		.error     (error)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb_sliding_window_max_queue NOT OK");
			$finish;
		end
	end

	// Result of the previous command may show in the edge that accepts the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_status(max_value, is_empty, count, error);
			if (start && !busy)
				sb.note_command(cmd, value);
		end
	end

	function automatic int idle_gap();
		if (no_idle)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(6, 30);
		return $urandom_range(0, 2);
	endfunction

	// Value shapes: wide random, small with many repeats, corner values, rising, falling.
	function automatic logic [VALUE_WIDTH-1:0] pick_value(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 7);
			2: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
					default: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
				endcase
			end
			3: begin
				trend = trend + $urandom_range(0, 3);
				return trend;
			end
			default: begin
				trend = trend - $urandom_range(0, 3);
				return trend;
			end
		endcase
	endfunction

	// Hold start high until the beat is taken.
	task send(logic [1:0] c, logic [VALUE_WIDTH-1:0] v);
		int gap;
		gap = idle_gap();
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		value <= v;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task run_directed();
		no_idle = $urandom_range(0, 1);
		send(CMD_READ, '1);
		send(CMD_POP, '0);
		send(CMD_PUSH, '0);
		send(CMD_PUSH, '1);
		send(CMD_PUSH, 32'd5);
		send(CMD_READ, 32'd0);
		send(CMD_POP, '1);
		send(CMD_POP, '0);
		send(CMD_PUSH, 32'd7);
		send(CMD_PUSH, 32'd7);
		send(CMD_PUSH, 32'd3);
		send(CMD_POP, 32'd0);
		send(CMD_POP, 32'd0);
		send(CMD_POP, 32'd0);
		send(CMD_POP, 32'd0);
		send(CMD_POP, 32'd0);
		send(CMD_PUSH, 32'hAAAA_AAAA);
		send(CMD_PUSH, 32'h5555_5555);
		send(CMD_CLEAR, '1);
		send(CMD_READ, 32'd0);
		send(CMD_PUSH, 32'd1);
		send(CMD_POP, 32'd0);
	endtask

	task run_random();
		int phase;
		int kind;
		int mode;
		int r;
		phase = 0;
		while (sent < ITEMS) begin
			kind    = (phase == 0) ? 0 : $urandom_range(0, 9);
			mode    = $urandom_range(0, 4);
			no_idle = ($urandom_range(0, 3) == 0);
			trend   = $urandom();
			if (kind == 0) begin
				// fill to the top, then push into a full queue
				while (sb.fifo_cnt < DEPTH)
					send(CMD_PUSH, pick_value(mode));
				repeat ($urandom_range(1, 3)) send(CMD_PUSH, pick_value(0));
			end else if (kind <= 2) begin
				while (sb.fifo_cnt > 0)
					send(CMD_POP, pick_value(0));
				repeat ($urandom_range(0, 2)) send(CMD_POP, pick_value(0));
			end else if (kind == 3) begin
				send(CMD_CLEAR, pick_value(0));
				send(CMD_READ, pick_value(0));
			end else begin
				repeat ($urandom_range(10, 60)) begin
					r = $urandom_range(0, 99);
					if ($urandom_range(0, 7) == 0)
						mode = $urandom_range(0, 4);
					if (r < 55)
						send(CMD_PUSH, pick_value(mode));
					else if (r < 85)
						send(CMD_POP, pick_value(0));
					else if (r < 93)
						send(CMD_READ, pick_value(0));
					else
						send(CMD_CLEAR, pick_value(0));
				end
			end
			phase++;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		@(negedge clk);
		start <= 1'b0;
		while (sb.status_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.status_due.size() == 0) begin
			$display("tb_sliding_window_max_queue OK");
		end else begin
			$display("tb_sliding_window_max_queue NOT OK");
		end
		$finish;
	end

endmodule
